### src/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define PB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/pbnp_pkg.sv
// Shared types and codes of the point store and pair search.
`default_nettype none
package pbnp_pkg;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_SCAN = 2'd2;

  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_BOUND  = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [15:0] STEP_RST   = 16'd328;
  localparam logic [14:0] BOUND_RST  = 15'd16220;
  localparam logic [14:0] RADIUS_RST = 15'd4915;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic [7:0]         cr;
    logic [7:0]         cg;
    logic [7:0]         cb;
  } point_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
    logic [7:0] cr;
    logic [7:0] cg;
    logic [7:0] cb;
  } pair_t;

endpackage
`default_nettype wire

### src/particle_bounce_and_neighbor_pairs.sv
// Top level: point ring with motion update and fixed-radius pair search.
//
//  channel   handshake                     beat
//  --------  ----------------------------  ------------------------------
//  request   start & !busy                 req_type, point_index, point
//  result    result_valid_o (no stall)     pair_found .. line_blue
//  config    psel & penable & pwrite       paddr[3:2] selects, pwdata
//
// A load writes its cell and leaves busy low. A tick or a scan rotates the
// ring of POINT_COUNT cells once through the head, and a scan then passes
// through the drain states DRN1 and DRN2.
// The scanned row is picked up as it passes the head, before its partners.
// Reset clears control and config; cell contents are undefined until loaded.
// Results leave from a register, one beat per cycle; the receiver cannot
// hold them off, so no stall path exists.
`default_nettype none
`include "assert_macros.svh"
module particle_bounce_and_neighbor_pairs #(
  parameter int POINT_COUNT = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  req_type_i,
  input  wire  [5:0]  point_index_i,
  input  wire  [15:0] pos_x_i,
  input  wire  [15:0] pos_y_i,
  input  wire  [15:0] pos_z_i,
  input  wire  [15:0] vel_x_i,
  input  wire  [15:0] vel_y_i,
  input  wire  [15:0] vel_z_i,
  input  wire  [7:0]  red_in_i,
  input  wire  [7:0]  green_in_i,
  input  wire  [7:0]  blue_in_i,
  output logic        result_valid_o,
  output logic        pair_found_o,
  output logic        last_of_run_o,
  output logic [5:0]  first_point_o,
  output logic [5:0]  second_point_o,
  output logic [7:0]  line_red_o,
  output logic [7:0]  line_green_o,
  output logic [7:0]  line_blue_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pbnp_pkg::*;

  localparam int IDX_W = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINT_COUNT - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TICK  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRN1  = 3'd3;
  localparam logic [2:0] ST_DRN2  = 3'd4;

  // config registers
  logic [15:0] step_q;
  logic [14:0] bound_q;
  logic [14:0] radius_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_RST;
      bound_q  <= BOUND_RST;
      radius_q <= RADIUS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_STEP:   step_q   <= pwdata[15:0];
        REG_BOUND:  bound_q  <= pwdata[14:0];
        REG_RADIUS: radius_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP:   prdata = {16'd0, step_q};
      REG_BOUND:  prdata = {17'd0, bound_q};
      REG_RADIUS: prdata = {17'd0, radius_q};
      default:    prdata = 32'd0;
    endcase
  end

  // sequencer
  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] ctr_q, ctr_d;
  logic             accept, idx_ok;
  logic [IDX_W-1:0] idx_w;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign idx_w  = IDX_W'(point_index_i);
  assign idx_ok = (32'(point_index_i) < 32'(POINT_COUNT));

  always_comb begin
    state_d = state_q;
    ctr_d   = ctr_q;
    case (state_q)
      ST_IDLE: begin
        ctr_d = '0;
        if (accept && req_type_i == REQ_TICK) state_d = ST_TICK;
        if (accept && req_type_i == REQ_SCAN) state_d = ST_SCAN;
      end
      ST_TICK: begin
        ctr_d = ctr_q + 1'b1;
        if (ctr_q == IDX_LAST) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        ctr_d = ctr_q + 1'b1;
        if (ctr_q == IDX_LAST) state_d = ST_DRN1;
      end
      ST_DRN1: state_d = ST_DRN2;
      ST_DRN2: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
    end
  end

  // ring of cells: cell k takes from k+1, the last takes from the head unit
  point_t cell_pt [POINT_COUNT];
  point_t head_nxt, load_pt;
  logic   shift;

  assign shift = (state_q == ST_TICK) || (state_q == ST_SCAN);

  always_comb begin
    load_pt.px = pos_x_i;
    load_pt.py = pos_y_i;
    load_pt.pz = pos_z_i;
    load_pt.vx = vel_x_i;
    load_pt.vy = vel_y_i;
    load_pt.vz = vel_z_i;
    load_pt.cr = red_in_i;
    load_pt.cg = green_in_i;
    load_pt.cb = blue_in_i;
  end

  for (genvar k = 0; k < POINT_COUNT; k++) begin : g_cell
    logic ld;
    assign ld = accept && (req_type_i == REQ_LOAD) && idx_ok &&
                (idx_w == IDX_W'(k));
    pbnp_cell u_cell (
      .clk_i     (clk_i),
      .load_i    (ld),
      .load_d_i  (load_pt),
      .shift_i   (shift),
      .shift_d_i ((k == POINT_COUNT - 1) ? head_nxt : cell_pt[(k + 1) % POINT_COUNT]),
      .pt_o      (cell_pt[k])
    );
  end

  pbnp_advance u_adv (
    .tick_i  (state_q == ST_TICK),
    .step_i  (step_q),
    .bound_i (bound_q),
    .pt_i    (cell_pt[0]),
    .pt_o    (head_nxt)
  );

  // scan row index, squared radius, and the row point taken at the head
  point_t      row_q;
  logic [5:0]  rowi_q;
  logic [29:0] lim_q;
  logic        s1_vld;
  logic [31:0] ctr_ext;
  pair_t       pr;

  assign ctr_ext = 32'(ctr_q);
  assign s1_vld  = (state_q == ST_SCAN) && (ctr_ext > 32'(rowi_q));

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_SCAN) begin
      rowi_q <= point_index_i;
      lim_q  <= radius_q * radius_q;
    end
    // head holds point ctr; the row passes before any of its partners
    if (state_q == ST_SCAN && ctr_ext == 32'(rowi_q)) row_q <= cell_pt[0];
  end

  pbnp_pair u_pair (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld),
    .row_i  (row_q),
    .head_i (cell_pt[0]),
    .idx_i  (ctr_ext[5:0]),
    .lim_i  (lim_q),
    .pair_o (pr)
  );

  // one-deep hold: a pair is sent once the next one (or the end) is known
  logic  hold_vld_q;
  pair_t hold_q;
  logic  emit, emit_last, emit_found;
  pair_t emit_pr;

  always_comb begin
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_found = 1'b1;
    emit_pr    = hold_q;
    if (pr.hit && hold_vld_q) begin
      emit = 1'b1;
    end
    if (state_q == ST_DRN2) begin
      emit      = 1'b1;
      emit_last = 1'b1;
      if (!hold_vld_q) begin
        emit_found = 1'b0;
        emit_pr    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q     <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      if (accept) hold_vld_q <= 1'b0;
      else if (pr.hit) hold_vld_q <= 1'b1;
      else if (state_q == ST_DRN2) hold_vld_q <= 1'b0;
      result_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pr.hit) hold_q <= pr;
    pair_found_o   <= emit_found;
    last_of_run_o  <= emit_last;
    first_point_o  <= rowi_q;
    second_point_o <= emit_pr.idx;
    line_red_o     <= emit_pr.cr;
    line_green_o   <= emit_pr.cg;
    line_blue_o    <= emit_pr.cb;
  end

  // no pair test in flight outside a scan
  `PB_ASSERT(a_pair_in_scan, pr.hit |-> (state_q == ST_SCAN || state_q == ST_DRN1), "pair hit outside scan")
  // drain always ends in a final beat
  `PB_ASSERT(a_drain_last, (state_q == ST_DRN2) |=> (result_valid_o && last_of_run_o), "scan ended without last beat")
  // a scan request raises busy
  `PB_ASSERT(a_scan_busy, (accept && req_type_i == REQ_SCAN) |=> busy, "scan not started")

endmodule
`default_nettype wire

### src/pbnp_cell.sv
// One storage cell of the point ring.
`default_nettype none
module pbnp_cell (
  input  wire                  clk_i,
  input  wire                  load_i,
  input  pbnp_pkg::point_t     load_d_i,
  input  wire                  shift_i,
  input  pbnp_pkg::point_t     shift_d_i,
  output pbnp_pkg::point_t     pt_o
);
  import pbnp_pkg::*;

  point_t pt_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pt_q <= load_d_i;
    end else if (shift_i) begin
      pt_q <= shift_d_i;
    end
  end

  assign pt_o = pt_q;

endmodule
`default_nettype wire

### src/pbnp_advance.sv
// Motion update at the ring head: move, saturate, reflect.
`default_nettype none
module pbnp_advance (
  input  wire               tick_i,
  input  wire        [15:0] step_i,
  input  wire        [14:0] bound_i,
  input  pbnp_pkg::point_t  pt_i,
  output pbnp_pkg::point_t  pt_o
);
  import pbnp_pkg::*;

  function automatic logic [31:0] axis_upd(input logic signed [15:0] p,
                                           input logic signed [15:0] v,
                                           input logic [15:0] s,
                                           input logic [14:0] b);
    logic signed [32:0] prod;
    logic signed [32:0] rnd;
    logic signed [17:0] sum;
    logic signed [15:0] np;
    logic signed [15:0] nv;
    logic [16:0]        mag;
    prod = v * $signed({1'b0, s});
    rnd  = prod + 33'sd32768;
    sum  = {p[15], p[15], p} + {rnd[32], rnd[32:16]};
    if (sum > 18'sd32767) np = 16'sh7fff;
    else if (sum < -18'sd32768) np = 16'sh8000;
    else np = sum[15:0];
    mag = np[15] ? (17'd0 - {np[15], np}) : {1'b0, np};
    nv  = v;
    if (mag >= {2'b00, b}) begin
      nv = (v == 16'sh8000) ? 16'sh7fff : -v;
    end
    return {np, nv};
  endfunction

  logic [31:0] ux, uy, uz;

  always_comb begin
    ux = axis_upd(pt_i.px, pt_i.vx, step_i, bound_i);
    uy = axis_upd(pt_i.py, pt_i.vy, step_i, bound_i);
    uz = axis_upd(pt_i.pz, pt_i.vz, step_i, bound_i);
    pt_o = pt_i;
    if (tick_i) begin
      pt_o.px = ux[31:16];
      pt_o.vx = ux[15:0];
      pt_o.py = uy[31:16];
      pt_o.vy = uy[15:0];
      pt_o.pz = uz[31:16];
      pt_o.vz = uz[15:0];
    end
  end

endmodule
`default_nettype wire

### src/pbnp_pair.sv
// Pair test: registered squares, then sum and compare with the limit.
`default_nettype none
module pbnp_pair (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               vld_i,
  input  pbnp_pkg::point_t  row_i,
  input  pbnp_pkg::point_t  head_i,
  input  wire        [5:0]  idx_i,
  input  wire        [29:0] lim_i,
  output pbnp_pkg::pair_t   pair_o
);
  import pbnp_pkg::*;

  logic signed [16:0] dx, dy, dz;
  logic signed [33:0] qx, qy, qz;
  logic [8:0]         sr, sg, sb;
  logic               vld_q;
  logic [32:0]        sqx_q, sqy_q, sqz_q;
  logic [34:0]        d2;
  pair_t              pr_q;

  always_comb begin
    dx = {row_i.px[15], row_i.px} - {head_i.px[15], head_i.px};
    dy = {row_i.py[15], row_i.py} - {head_i.py[15], head_i.py};
    dz = {row_i.pz[15], row_i.pz} - {head_i.pz[15], head_i.pz};
    qx = dx * dx;
    qy = dy * dy;
    qz = dz * dz;
    sr = {1'b0, row_i.cr} + {1'b0, head_i.cr};
    sg = {1'b0, row_i.cg} + {1'b0, head_i.cg};
    sb = {1'b0, row_i.cb} + {1'b0, head_i.cb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q     <= qx[32:0];
    sqy_q     <= qy[32:0];
    sqz_q     <= qz[32:0];
    pr_q.hit  <= 1'b0;
    pr_q.idx  <= idx_i;
    pr_q.cr   <= sr[8:1];
    pr_q.cg   <= sg[8:1];
    pr_q.cb   <= sb[8:1];
  end

  always_comb begin
    d2 = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
    pair_o     = pr_q;
    pair_o.hit = vld_q && (d2 < {5'd0, lim_i});
  end

endmodule
`default_nettype wire

### tb/sv/pair_checker.sv
// Checker: predicts point store behavior and compares result beats.
`timescale 1ns / 1ps
module pair_checker
  import pbnp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  point_index_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic [15:0] vel_x_i,
  input  logic [15:0] vel_y_i,
  input  logic [15:0] vel_z_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic        result_valid_o,
  input  logic        pair_found_o,
  input  logic        last_of_run_o,
  input  logic [5:0]  first_point_o,
  input  logic [5:0]  second_point_o,
  input  logic [7:0]  line_red_o,
  input  logic [7:0]  line_green_o,
  input  logic [7:0]  line_blue_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_pairs
);
  typedef struct packed {
    logic       hit;
    logic       last;
    logic [5:0] row;
    logic [5:0] mate;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pair_beat_t;

  localparam int NPTS = 64;

  logic signed [15:0] pos_q [NPTS][3];
  logic signed [15:0] vel_q [NPTS][3];
  logic [7:0]         col_q [NPTS][3];
  logic [15:0] step_q;
  logic [14:0] bound_q;
  logic [14:0] radius_q;
  pair_beat_t  pair_fifo[$];

  assign pending_pairs = pair_fifo.size();

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // one tick over every point; rounding is floor((v*s + 2^15) / 2^16)
  task automatic advance_points();
    longint prod, moved, mag;
    for (int k = 0; k < NPTS; k++)
      for (int a = 0; a < 3; a++) begin
        prod = longint'(vel_q[k][a]) * longint'({1'b0, step_q}) + 32768;
        moved = prod >>> 16;
        pos_q[k][a] = clamp16(longint'(pos_q[k][a]) + moved);
        mag = pos_q[k][a] < 0 ? -longint'(pos_q[k][a]) : longint'(pos_q[k][a]);
        if (mag >= bound_q) vel_q[k][a] = clamp16(-longint'(vel_q[k][a]));
      end
  endtask

  task automatic scan_row(int row);
    longint d, d2, lim;
    pair_beat_t pb;
    int found;
    found = 0;
    lim = longint'(radius_q) * longint'(radius_q);
    for (int j = row + 1; j < NPTS; j++) begin
      d2 = 0;
      for (int a = 0; a < 3; a++) begin
        d = longint'(pos_q[row][a]) - longint'(pos_q[j][a]);
        d2 += d * d;
      end
      if (d2 < lim) begin
        pb.hit = 1'b1; pb.last = 1'b0; pb.row = row; pb.mate = j;
        pb.r = (9'(col_q[row][0]) + 9'(col_q[j][0])) >> 1;
        pb.g = (9'(col_q[row][1]) + 9'(col_q[j][1])) >> 1;
        pb.b = (9'(col_q[row][2]) + 9'(col_q[j][2])) >> 1;
        pair_fifo.push_back(pb);
        found++;
      end
    end
    if (found == 0) begin
      pb = '0; pb.last = 1'b1; pb.row = row;
      pair_fifo.push_back(pb);
    end else begin
      pair_fifo[pair_fifo.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pair_beat_t got, want;
    if (!rst_ni) begin
      step_q <= STEP_RST;
      bound_q <= BOUND_RST;
      radius_q <= RADIUS_RST;
      fail_count <= 0;
      for (int k = 0; k < NPTS; k++)
        for (int a = 0; a < 3; a++) begin
          pos_q[k][a] = '0; vel_q[k][a] = '0; col_q[k][a] = '0;
        end
    end else begin
      // result beat first: it was caused by an earlier request
      if (result_valid_o) begin
        got = '{pair_found_o, last_of_run_o, first_point_o, second_point_o,
                line_red_o, line_green_o, line_blue_o};
        if (pair_fifo.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = pair_fifo.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch exp %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_STEP:   step_q <= pwdata[15:0];
          REG_BOUND:  bound_q <= pwdata[14:0];
          REG_RADIUS: radius_q <= pwdata[14:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (req_type_i)
          REQ_LOAD: begin
            pos_q[point_index_i] = '{pos_x_i, pos_y_i, pos_z_i};
            vel_q[point_index_i] = '{vel_x_i, vel_y_i, vel_z_i};
            col_q[point_index_i] = '{red_in_i, green_in_i, blue_in_i};
          end
          REQ_TICK: advance_points();
          REQ_SCAN: scan_row(point_index_i);
          default: ;
        endcase
      end
    end
  end
endmodule

### tb/sv/testbench.sv
// Testbench top: stimulus, register phases and verdict for the point store.
`timescale 1ns / 1ps
module testbench;
  import pbnp_pkg::*;

  logic        clk_i, rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  req_type_i;
  logic [5:0]  point_index_i;
  logic [15:0] pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i;
  logic [7:0]  red_in_i, green_in_i, blue_in_i;
  logic        result_valid_o, pair_found_o, last_of_run_o;
  logic [5:0]  first_point_o, second_point_o;
  logic [7:0]  line_red_o, line_green_o, line_blue_o;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending_pairs;
  int          cycle_count;
  bit          calm;   // no idle gaps while set
  int          sent;

  particle_bounce_and_neighbor_pairs dut (.*);
  pair_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: all scans of the run plus gaps fit well inside this limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("particle_bounce_and_neighbor_pairs regression: fail");
      $finish;
    end
  end

  // one request beat; random idle before it, then waits for acceptance.
  // start stays high after acceptance until the next beat or an idle cycle.
  task automatic issue(logic [1:0] kind, logic [5:0] idx,
                       logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                       logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!calm && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= kind; point_index_i <= idx;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    vel_x_i <= vx; vel_y_i <= vy; vel_z_i <= vz;
    red_in_i <= r; green_in_i <= g; blue_in_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic load_pt(int idx, logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                         logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
    issue(REQ_LOAD, idx, px, py, pz, vx, vy, vz,
          $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // random point; clustered mode keeps points near each other so pairs appear
  task automatic load_rand(int idx, bit clustered);
    logic [15:0] p[3];
    for (int a = 0; a < 3; a++)
      p[a] = clustered ? 16'($signed($urandom_range(8000)) - 4000) : 16'($urandom);
    load_pt(idx, p[0], p[1], p[2], $urandom, $urandom, $urandom);
  endtask

  // let the block go quiet, then write a register over the bus
  task automatic write_reg(logic [1:0] which, logic [31:0] val);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {which, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int kind;
    cycle_count = 0; sent = 0; calm = 1'b0;
    start = 1'b0; req_type_i = REQ_LOAD; point_index_i = '0;
    {pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i} = '0;
    {red_in_i, green_in_i, blue_in_i} = '0;
    {psel, penable, pwrite} = '0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every entry written before any scan or tick reads it
    for (int k = 0; k < 64; k++) load_rand(k, 1'b1);
    load_pt(0, 16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff, 16'h0001);
    load_pt(1, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 16'hffff);
    issue(REQ_LOAD, 2, 0, 0, 0, 0, 0, 0, 8'hff, 8'hff, 8'hff);
    issue(REQ_LOAD, 3, 0, 0, 0, 0, 0, 0, 8'hff, 8'h00, 8'h01);
    issue(REQ_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(REQ_SCAN, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(REQ_SCAN, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0);  // last row: no partners
    issue(2'd3, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0);        // unused code, ignored
    issue(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(REQ_SCAN, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // register phases: extremes, reset values and random settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_STEP, 16'hffff); write_reg(REG_BOUND, 0);
                 write_reg(REG_RADIUS, 15'h7fff); end
        1: begin write_reg(REG_STEP, 0); write_reg(REG_BOUND, 15'h7fff);
                 write_reg(REG_RADIUS, 0); end
        2: begin write_reg(REG_STEP, STEP_RST); write_reg(REG_BOUND, BOUND_RST);
                 write_reg(REG_RADIUS, RADIUS_RST); end
        default: begin write_reg(REG_STEP, $urandom_range(65535));
                 write_reg(REG_BOUND, $urandom_range(32767));
                 write_reg(REG_RADIUS, $urandom_range(1000, 12000)); end
      endcase
      calm = (phase == 3);  // one phase runs with no idle gaps
      for (int n = 0; n < 43; n++) begin
        kind = $urandom_range(99);
        if (kind < 35) load_rand($urandom_range(63), $urandom_range(3) != 0);
        else if (kind < 55) issue(REQ_TICK, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom);
        else if (kind < 97) issue(REQ_SCAN, $urandom, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        else issue(2'd3, $urandom, $urandom, 0, 0, 0, 0, 0, 0, 0, 0);
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0)
      $display("particle_bounce_and_neighbor_pairs regression: pass");
    else
      $display("particle_bounce_and_neighbor_pairs regression: fail");
    $finish;
  end
endmodule
